// ===== rtl/core/dcc_pkg.sv =====
// shared types and constants for the dcc packet bit serializer
// used by dcc_frame_build, dcc_bit_seq and dcc_packet_bit_serializer_core
package dcc_pkg;

    localparam int SYMBOL_WIDTH = 16;
    localparam logic [15:0] SYM_MASK = (SYMBOL_WIDTH >= 16) ? 16'hFFFF
                                     : 16'((32'd1 << SYMBOL_WIDTH) - 32'd1);

    // request kinds
    localparam logic [1:0] REQ_THROTTLE = 2'd0;
    localparam logic [1:0] REQ_IDLE     = 2'd1;
    localparam logic [1:0] REQ_RESET    = 2'd2;

    // register indexes
    localparam logic [2:0] REG_POWER    = 3'd0;
    localparam logic [2:0] REG_PREAMBLE = 3'd1;
    localparam logic [2:0] REG_CLOSER   = 3'd2;
    localparam logic [2:0] REG_ZERO     = 3'd3;
    localparam logic [2:0] REG_ONE      = 3'd4;

    localparam logic [4:0] PREAMBLE_MAX   = 5'd20;
    localparam logic [3:0] CLOSER_MAX     = 4'd8;
    localparam logic [4:0] PREAMBLE_RESET = 5'd14;
    localparam logic [3:0] CLOSER_RESET   = 4'd1;

    localparam int FRAME_BITS = 36;   // four bytes with their start bits
    localparam int CNT_W      = 6;

    localparam logic [7:0] CMD_BASE   = 8'h40;
    localparam logic [7:0] LONG_BASE  = 8'hC0;
    localparam logic [13:0] SHORT_MAX = 14'd127;

    typedef struct packed {
        logic                  send;    // request kind produces a packet
        logic [FRAME_BITS-1:0] bits;    // start bits and data, msb first
        logic [CNT_W-1:0]      nbits;   // 27 or 36
    } t_frame;

    typedef struct packed {
        logic valid;
        logic bit_value;
        logic last;
    } t_sym;

endpackage

// ===== rtl/core/dcc_packet_bit_serializer_core.sv =====
// dcc packet bit serializer: config registers, request port, output register
// depends on dcc_pkg, dcc_frame_build and dcc_bit_seq
//
// usage:
//   a request (throttle, idle or reset packet) enters on the s_axis group;
//   the packet leaves on the m_axis group as one symbol per track bit:
//   preamble ones, each byte as a zero start bit and 8 bits msb first,
//   the xor error byte, then closer ones; tlast marks the final closer bit.
//   symbol words and lengths come from the apb registers.
//   write them while idle only; the block itself does not enforce this.
//   a request loads the sequencer; each symbol is registered at the output.
//   throughput: a packet is preamble + 9 * bytes + closer symbols (28 to 64),
//   one per cycle while the receiver takes them, from the single sequencer
//   counter and shift register; the next request is taken once the last
//   symbol has left the sequencer. with track power off or an unknown
//   request kind a request is taken and dropped, the sequencer stays idle.
//   a receiver stall holds the output register and freezes the sequencer;
//   no symbol is lost or repeated.
//   reset: registers return to power off, preamble 14, closer 1,
//   zero code 0, one code 1; sequencer idle, output empty.
module dcc_packet_bit_serializer_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request: cab_address[13:0], speed_step[18:14], direction[19], zero pad
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,
    input  logic [1:0]  s_axis_tuser,   // req_type[1:0]
    // symbol: symbol_code[15:0], bit_value[16], zero pad
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,
    output logic        m_axis_tlast,   // last_symbol
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import dcc_pkg::*;

    logic        r_power;
    logic [4:0]  r_preamble;
    logic [3:0]  r_closer;
    logic [15:0] r_zero_code;
    logic [15:0] r_one_code;

    logic        r_out_valid;
    logic [15:0] r_out_code;
    logic        r_out_bit;
    logic        r_out_last;

    logic [2:0] reg_idx;
    logic       wr_en;
    logic       start;
    logic       adv;
    logic       seq_idle;
    t_frame     frame;
    t_sym       sym;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;

    always_comb begin
        unique case (reg_idx)
            REG_POWER:    prdata = {31'd0, r_power};
            REG_PREAMBLE: prdata = {27'd0, r_preamble};
            REG_CLOSER:   prdata = {28'd0, r_closer};
            REG_ZERO:     prdata = {16'd0, r_zero_code};
            REG_ONE:      prdata = {16'd0, r_one_code};
            default:      prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_power     <= 1'b0;
            r_preamble  <= PREAMBLE_RESET;
            r_closer    <= CLOSER_RESET;
            r_zero_code <= 16'd0;
            r_one_code  <= 16'd1;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_POWER:    r_power     <= pwdata[0];
                REG_PREAMBLE: r_preamble  <= pwdata[4:0];
                REG_CLOSER:   r_closer    <= pwdata[3:0];
                REG_ZERO:     r_zero_code <= pwdata[15:0];
                REG_ONE:      r_one_code  <= pwdata[15:0];
                default:      ;
            endcase
        end
    end

    assign s_axis_tready = seq_idle;
    assign start         = s_axis_tvalid && seq_idle;
    assign adv           = !r_out_valid || m_axis_tready;

    dcc_frame_build u_build (
        .i_req_type    (s_axis_tuser),
        .i_cab_address (s_axis_tdata[13:0]),
        .i_speed_step  (s_axis_tdata[18:14]),
        .i_direction   (s_axis_tdata[19]),
        .o_frame       (frame)
    );

    dcc_bit_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_frame    (frame),
        .i_power    (r_power),
        .i_preamble (r_preamble),
        .i_closer   (r_closer),
        .i_adv      (adv),
        .o_idle     (seq_idle),
        .o_sym      (sym)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (sym.valid) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (sym.valid) begin
            r_out_code <= (sym.bit_value ? r_one_code : r_zero_code) & SYM_MASK;
            r_out_bit  <= sym.bit_value;
            r_out_last <= sym.last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_out_bit, r_out_code};
    assign m_axis_tlast  = r_out_last;

endmodule

// ===== rtl/core/dcc_frame_build.sv =====
// builds the start-bit framed byte string of one packet, error byte included
// depends on dcc_pkg
module dcc_frame_build (
    input  logic [1:0]      i_req_type,
    input  logic [13:0]     i_cab_address,
    input  logic [4:0]      i_speed_step,
    input  logic            i_direction,
    output dcc_pkg::t_frame o_frame
);
    import dcc_pkg::*;

    logic [7:0] cmd;
    logic [7:0] b0, b1, b2, chk;
    logic       long_form;

    always_comb begin
        cmd       = CMD_BASE | {2'b00, i_direction, i_speed_step};
        long_form = 1'b0;
        b0        = 8'h00;
        b1        = 8'h00;
        b2        = 8'h00;
        o_frame.send = 1'b1;
        unique case (i_req_type)
            REQ_THROTTLE: begin
                if (i_cab_address > SHORT_MAX) begin
                    long_form = 1'b1;
                    b0 = LONG_BASE | {2'b00, i_cab_address[13:8]};
                    b1 = i_cab_address[7:0];
                    b2 = cmd;
                end else begin
                    b0 = i_cab_address[7:0];
                    b1 = cmd;
                end
            end
            REQ_IDLE: begin
                b0 = 8'hFF;
            end
            REQ_RESET: begin
                b0 = 8'h00;
            end
            default: begin
                o_frame.send = 1'b0;
            end
        endcase
        chk = b0 ^ b1 ^ b2;
        if (long_form) begin
            o_frame.bits  = {1'b0, b0, 1'b0, b1, 1'b0, b2, 1'b0, chk};
            o_frame.nbits = CNT_W'(36);
        end else begin
            o_frame.bits  = {1'b0, b0, 1'b0, b1, 1'b0, chk, 9'd0};
            o_frame.nbits = CNT_W'(27);
        end
    end

endmodule

// ===== rtl/core/dcc_bit_seq.sv =====
// packet sequencer: one shared down counter walks preamble, data and closer
// and a shift register hands out the data bits; depends on dcc_pkg
module dcc_bit_seq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,     // request accepted
    input  dcc_pkg::t_frame i_frame,
    input  logic            i_power,
    input  logic [4:0]      i_preamble,
    input  logic [3:0]      i_closer,
    input  logic            i_adv,       // output slot can take a symbol
    output logic            o_idle,
    output dcc_pkg::t_sym   o_sym
);
    import dcc_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_PRE  = 2'd1;
    localparam logic [1:0] S_DATA = 2'd2;
    localparam logic [1:0] S_CLO  = 2'd3;

    logic [1:0]            r_state, n_state;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic [FRAME_BITS-1:0] r_shift, n_shift;
    logic [CNT_W-1:0]      r_nbits, n_nbits;
    logic [3:0]            r_clo, n_clo;

    logic [4:0] pre_eff;
    logic [3:0] clo_eff;
    logic       cnt_end;

    assign pre_eff = (i_preamble > PREAMBLE_MAX) ? PREAMBLE_MAX : i_preamble;
    assign clo_eff = (i_closer == 4'd0) ? 4'd1
                   : ((i_closer > CLOSER_MAX) ? CLOSER_MAX : i_closer);
    assign cnt_end = (r_cnt == CNT_W'(1));
    assign o_idle  = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_shift = r_shift;
        n_nbits = r_nbits;
        n_clo   = r_clo;
        o_sym.valid     = 1'b0;
        o_sym.bit_value = 1'b1;
        o_sym.last      = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start && i_power && i_frame.send) begin
                    n_shift = i_frame.bits;
                    n_nbits = i_frame.nbits;
                    n_clo   = clo_eff;
                    // a zero preamble goes straight to the first start bit
                    if (pre_eff == 5'd0) begin
                        n_state = S_DATA;
                        n_cnt   = i_frame.nbits;
                    end else begin
                        n_state = S_PRE;
                        n_cnt   = CNT_W'(pre_eff);
                    end
                end
            end
            S_PRE: begin
                if (i_adv) begin
                    o_sym.valid = 1'b1;
                    n_cnt = r_cnt - CNT_W'(1);
                    if (cnt_end) begin
                        n_state = S_DATA;
                        n_cnt   = r_nbits;
                    end
                end
            end
            S_DATA: begin
                o_sym.bit_value = r_shift[FRAME_BITS-1];
                if (i_adv) begin
                    o_sym.valid = 1'b1;
                    n_shift = {r_shift[FRAME_BITS-2:0], 1'b0};
                    n_cnt   = r_cnt - CNT_W'(1);
                    if (cnt_end) begin
                        n_state = S_CLO;
                        n_cnt   = CNT_W'(r_clo);
                    end
                end
            end
            S_CLO: begin
                o_sym.last = cnt_end;
                if (i_adv) begin
                    o_sym.valid = 1'b1;
                    n_cnt = r_cnt - CNT_W'(1);
                    if (cnt_end) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
        r_shift <= n_shift;
        r_nbits <= n_nbits;
        r_clo   <= n_clo;
    end

endmodule
